@@ rtl/pwvcs_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pwvcs_pkg: shared types and constants
// Phase codes, register indexes and the bundles passed between the
// register bank, the sequencer and the result queue.
// ---------------------------------------------------------------------------
package pwvcs_pkg;

   localparam int CFG_TIME_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_LOW   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_LOW   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_PHASE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PHASE  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GUARD       = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUSY_LEVEL  = 3'd6;

   localparam logic [CFG_TIME_WIDTH-1:0] RESET_LOW_DEFAULT   = 16'd5000;
   localparam logic [CFG_TIME_WIDTH-1:0] RESET_HIGH_DEFAULT  = 16'd20000;
   localparam logic [CFG_TIME_WIDTH-1:0] START_LOW_DEFAULT   = 16'd5000;
   localparam logic [CFG_TIME_WIDTH-1:0] SHORT_PHASE_DEFAULT = 16'd200;
   localparam logic [CFG_TIME_WIDTH-1:0] LONG_PHASE_DEFAULT  = 16'd600;
   localparam logic [CFG_TIME_WIDTH-1:0] GUARD_DEFAULT       = 16'd24000;
   localparam logic                      BUSY_LEVEL_DEFAULT  = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_RESET_LOW  = 3'd1,
      PH_RESET_HIGH = 3'd2,
      PH_START_LOW  = 3'd3,
      PH_BITS       = 3'd4,
      PH_GUARD      = 3'd5
   } phase_type;

   typedef struct packed {
      logic [CFG_TIME_WIDTH-1:0] reset_low_ticks;
      logic [CFG_TIME_WIDTH-1:0] reset_high_ticks;
      logic [CFG_TIME_WIDTH-1:0] start_low_ticks;
      logic [CFG_TIME_WIDTH-1:0] short_phase_ticks;
      logic [CFG_TIME_WIDTH-1:0] long_phase_ticks;
      logic [CFG_TIME_WIDTH-1:0] guard_ticks;
      logic                      busy_active_level;
   } cfg_type;

   typedef struct packed {
      logic data_level;
      logic reset_level;
      logic sending;
      logic frame_done;
      logic send_rejected;
      logic chip_playing;
   } result_type;

endpackage : pwvcs_pkg
`default_nettype wire

@@ rtl/pwvcs_csr.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pwvcs_csr: configuration register bank
// Holds the phase timings and the busy pin active level. Writes to
// unused indexes are dropped.
// ---------------------------------------------------------------------------
module pwvcs_csr
   import pwvcs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_TIME_WIDTH-1:0]  csr_data,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RESET_LOW:   cfg_in.reset_low_ticks   = csr_data;
            CSR_RESET_HIGH:  cfg_in.reset_high_ticks  = csr_data;
            CSR_START_LOW:   cfg_in.start_low_ticks   = csr_data;
            CSR_SHORT_PHASE: cfg_in.short_phase_ticks = csr_data;
            CSR_LONG_PHASE:  cfg_in.long_phase_ticks  = csr_data;
            CSR_GUARD:       cfg_in.guard_ticks       = csr_data;
            CSR_BUSY_LEVEL:  cfg_in.busy_active_level = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks   <= RESET_LOW_DEFAULT;
         cfg_ff.reset_high_ticks  <= RESET_HIGH_DEFAULT;
         cfg_ff.start_low_ticks   <= START_LOW_DEFAULT;
         cfg_ff.short_phase_ticks <= SHORT_PHASE_DEFAULT;
         cfg_ff.long_phase_ticks  <= LONG_PHASE_DEFAULT;
         cfg_ff.guard_ticks       <= GUARD_DEFAULT;
         cfg_ff.busy_active_level <= BUSY_LEVEL_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : pwvcs_csr
`default_nettype wire

@@ rtl/pwvcs_seq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pwvcs_seq: frame sequencer
// Phase state machine with a down-counting phase timer. One transaction
// (tick or send request) is applied per cycle while accept is high; the
// result reflects the state after the transaction.
// ---------------------------------------------------------------------------
module pwvcs_seq
   import pwvcs_pkg::*;
#(
   parameter int CODE_BITS   = 8,
   parameter int TIMER_WIDTH = 16
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       accept,
   input  wire logic       req_type,
   input  wire logic [7:0] send_code,
   input  wire logic       chip_busy_pin,
   output result_type      result
);

   localparam int BCW = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
   localparam logic [BCW-1:0] LAST_BIT = BCW'(CODE_BITS - 1);
   localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

   phase_type              phase_ff,       phase_in;
   logic [TIMER_WIDTH-1:0] phase_timer_ff, phase_timer_in;
   logic [BCW-1:0]         bit_counter_ff, bit_counter_in;
   logic [CODE_BITS-1:0]   code_shift_ff,  code_shift_in;
   logic                   in_high_half_ff, in_high_half_in;
   logic                   done;
   logic                   rejected;
   logic [CODE_BITS-1:0]   code_next;

   assign code_next = code_shift_ff >> 1;

   always_comb begin
      phase_in        = phase_ff;
      phase_timer_in  = phase_timer_ff;
      bit_counter_in  = bit_counter_ff;
      code_shift_in   = code_shift_ff;
      in_high_half_in = in_high_half_ff;
      done            = 1'b0;
      rejected        = 1'b0;
      if (accept) begin
         if (req_type) begin
            if (phase_ff != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               phase_in        = PH_RESET_LOW;
               phase_timer_in  = TIMER_WIDTH'(cfg.reset_low_ticks);
               bit_counter_in  = '0;
               code_shift_in   = CODE_BITS'({{CODE_BITS{1'b0}}, send_code});
               in_high_half_in = 1'b0;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (phase_timer_ff > TIMER_ONE) begin
               phase_timer_in = phase_timer_ff - TIMER_ONE;
            end else begin
               case (phase_ff)
                  PH_RESET_LOW: begin
                     phase_in       = PH_RESET_HIGH;
                     phase_timer_in = TIMER_WIDTH'(cfg.reset_high_ticks);
                  end
                  PH_RESET_HIGH: begin
                     phase_in       = PH_START_LOW;
                     phase_timer_in = TIMER_WIDTH'(cfg.start_low_ticks);
                  end
                  PH_START_LOW: begin
                     phase_in        = PH_BITS;
                     bit_counter_in  = '0;
                     in_high_half_in = 1'b1;
                     phase_timer_in  = code_shift_ff[0] ?
                                       TIMER_WIDTH'(cfg.long_phase_ticks) :
                                       TIMER_WIDTH'(cfg.short_phase_ticks);
                  end
                  PH_BITS: begin
                     if (in_high_half_ff) begin
                        in_high_half_in = 1'b0;
                        phase_timer_in  = code_shift_ff[0] ?
                                          TIMER_WIDTH'(cfg.short_phase_ticks) :
                                          TIMER_WIDTH'(cfg.long_phase_ticks);
                     end else begin
                        code_shift_in = code_next;
                        if (bit_counter_ff == LAST_BIT) begin
                           phase_in       = PH_GUARD;
                           bit_counter_in = '0;
                           phase_timer_in = TIMER_WIDTH'(cfg.guard_ticks);
                        end else begin
                           bit_counter_in  = bit_counter_ff + BCW'(1);
                           in_high_half_in = 1'b1;
                           phase_timer_in  = code_next[0] ?
                                             TIMER_WIDTH'(cfg.long_phase_ticks) :
                                             TIMER_WIDTH'(cfg.short_phase_ticks);
                        end
                     end
                  end
                  default: begin
                     phase_in        = PH_IDLE;
                     phase_timer_in  = '0;
                     bit_counter_in  = '0;
                     code_shift_in   = '0;
                     in_high_half_in = 1'b0;
                     done            = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         phase_timer_ff  <= '0;
         bit_counter_ff  <= '0;
         code_shift_ff   <= '0;
         in_high_half_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         phase_timer_ff  <= phase_timer_in;
         bit_counter_ff  <= bit_counter_in;
         code_shift_ff   <= code_shift_in;
         in_high_half_ff <= in_high_half_in;
      end
   end

   always_comb begin
      result.data_level    = 1'b1;
      if (phase_in == PH_START_LOW) begin
         result.data_level = 1'b0;
      end else if (phase_in == PH_BITS) begin
         result.data_level = in_high_half_in;
      end
      result.reset_level   = (phase_in != PH_RESET_LOW);
      result.sending       = (phase_in != PH_IDLE);
      result.frame_done    = done;
      result.send_rejected = rejected;
      result.chip_playing  = (chip_busy_pin == cfg.busy_active_level);
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (phase_timer_ff == '0 && bit_counter_ff == '0 &&
                                 code_shift_ff == '0 && !in_high_half_ff))
      else $error("idle with leftover frame state");

   a_half_in_bits: assert property (@(posedge clock) disable iff (reset)
      in_high_half_ff |-> (phase_ff == PH_BITS))
      else $error("high half flag outside bit phase");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type && phase_ff != PH_IDLE) |=>
         ($stable(phase_ff) && $stable(phase_timer_ff) && $stable(code_shift_ff)))
      else $error("rejected send changed the frame state");

endmodule : pwvcs_seq
`default_nettype wire

@@ rtl/pwvcs_outq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pwvcs_outq: two-entry result queue
// Keeps the result channel apart from the request channel so a new
// transaction is taken while a finished result waits.
// ---------------------------------------------------------------------------
module pwvcs_outq
   import pwvcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            full,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      head
);

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (push) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full result queue");

   a_head_written: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd0) |=> (slot0_ff == $past(push_data)))
      else $error("result into empty queue not at head");

endmodule : pwvcs_outq
`default_nettype wire

@@ rtl/pulse_width_voice_command_sender.sv @@
`default_nettype none
// Results: a result is written into the result queue as its request transaction is taken.
// Throughput: one transaction per cycle; the two-entry result queue raises
// req_stall only when both entries hold results not yet taken.
// Reset: synchronous; timings return to their defaults, the sequencer goes
// idle and the result queue empties.
// ---------------------------------------------------------------------------
// pulse_width_voice_command_sender: one-wire voice chip command sender
// Sequences reset pulse, start mark, pulse-width coded bits and guard time
// from microsecond tick transactions.
// ---------------------------------------------------------------------------
module pulse_width_voice_command_sender
   import pwvcs_pkg::*;
#(
   parameter int CODE_BITS   = 8,
   parameter int TIMER_WIDTH = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_type,
   input  wire logic [7:0]                 req_code,
   input  wire logic                       req_chip_busy_pin,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_data_level,
   output logic                            rsp_reset_level,
   output logic                            rsp_sending,
   output logic                            rsp_frame_done,
   output logic                            rsp_send_rejected,
   output logic                            rsp_chip_playing,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_TIME_WIDTH-1:0]  csr_data
);

   cfg_type    cfg;
   result_type result;
   result_type head;
   logic       queue_full;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   pwvcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwvcs_seq #(
      .CODE_BITS   (CODE_BITS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .req_type      (req_type),
      .send_code     (req_code),
      .chip_busy_pin (req_chip_busy_pin),
      .result        (result)
   );

   pwvcs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_data_level    = head.data_level;
   assign rsp_reset_level   = head.reset_level;
   assign rsp_sending       = head.sending;
   assign rsp_frame_done    = head.frame_done;
   assign rsp_send_rejected = head.send_rejected;
   assign rsp_chip_playing  = head.chip_playing;

endmodule : pulse_width_voice_command_sender
`default_nettype wire

@@ verif/pulse_width_voice_command_sender_tb.sv @@
// ---------------------------------------------------------------------------
// pulse_width_voice_command_sender_tb: self-checking testbench
// Drives tick and send transactions into the sender and checks every line
// level result against an in-bench sequencer model or a typed table row.
// A directed table covers the reset state, zero timings and rejected sends;
// random traffic with bursty input, a varying output stall pattern and
// random timings follows, and a frame with maximum timings closes the run.
// ---------------------------------------------------------------------------
module pulse_width_voice_command_sender_tb;
   import pwvcs_pkg::*;

   localparam int CODE_BITS   = 8;
   localparam int QUIET_LIMIT = 4000;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   typedef enum logic [1:0] {ROW_TICK, ROW_SEND, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_pattern_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] reg_sel;
      logic [CFG_TIME_WIDTH-1:0]  value;
      logic                       busy;
      logic                       typed;
      result_type                 want;
   } directed_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_type = 1'b0;
   logic [7:0]                 req_code = '0;
   logic                       req_chip_busy_pin = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_data_level;
   logic                       rsp_reset_level;
   logic                       rsp_sending;
   logic                       rsp_frame_done;
   logic                       rsp_send_rejected;
   logic                       rsp_chip_playing;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_TIME_WIDTH-1:0]  csr_data = '0;

   // sequencer model state
   cfg_type                    cfg = '{RESET_LOW_DEFAULT, RESET_HIGH_DEFAULT, START_LOW_DEFAULT,
                                       SHORT_PHASE_DEFAULT, LONG_PHASE_DEFAULT, GUARD_DEFAULT,
                                       BUSY_LEVEL_DEFAULT};
   phase_type                  ph = PH_IDLE;
   logic [CFG_TIME_WIDTH-1:0]  ph_timer = '0;
   logic [3:0]                 bits_sent = '0;
   logic [7:0]                 code_sr = '0;
   logic                       high_half = 1'b0;

   result_type                 levels_due [$];
   int                         mismatch_count = 0;
   int                         burst_left = 0;
   int                         quiet_cycles = 0;
   stall_pattern_type          stall_mode = STALL_OFF;
   int                         stall_left = 0;
   logic [2:0]                 beat = '0;

   string field_name [6] = '{"chip_playing", "send_rejected", "frame_done",
                             "sending", "reset_level", "data_level"};

   // want bits: data, reset, sending, done, rejected, playing
   directed_row_type plan [20] = '{
      '{ROW_TICK,  '0,              16'h0000, 1'b0, 1'b1, 6'b110001},
      '{ROW_TICK,  '0,              16'h00FF, 1'b1, 1'b1, 6'b110000},
      '{ROW_WRITE, CSR_RESET_LOW,   16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_WRITE, CSR_RESET_HIGH,  16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_WRITE, CSR_START_LOW,   16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_WRITE, CSR_SHORT_PHASE, 16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_WRITE, CSR_LONG_PHASE,  16'h0002, 1'b0, 1'b0, 6'b000000},
      '{ROW_WRITE, CSR_GUARD,       16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_SEND,  '0,              16'h0000, 1'b0, 1'b1, 6'b101001},
      '{ROW_SEND,  '0,              16'h00FF, 1'b1, 1'b1, 6'b101010},
      '{ROW_TICK,  '0,              16'h0000, 1'b1, 1'b0, 6'b000000},
      '{ROW_TICK,  '0,              16'h00FF, 1'b0, 1'b0, 6'b000000},
      '{ROW_WRITE, CSR_BUSY_LEVEL,  16'h0001, 1'b0, 1'b0, 6'b000000},
      '{ROW_SEND,  '0,              16'h00FF, 1'b1, 1'b1, 6'b101001},
      '{ROW_TICK,  '0,              16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_SEND,  '0,              16'h0080, 1'b1, 1'b1, 6'b111011},
      '{ROW_TICK,  '0,              16'h0000, 1'b1, 1'b0, 6'b000000},
      '{ROW_TICK,  '0,              16'h0000, 1'b0, 1'b0, 6'b000000},
      '{ROW_TICK,  '0,              16'h0000, 1'b1, 1'b0, 6'b000000},
      '{ROW_TICK,  '0,              16'h0000, 1'b0, 1'b0, 6'b000000}
   };

   pulse_width_voice_command_sender #(
      .CODE_BITS  (CODE_BITS),
      .TIMER_WIDTH(CFG_TIME_WIDTH)
   ) DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bit half length: a 1 has long high / short low, a 0 the reverse
   function automatic logic [CFG_TIME_WIDTH-1:0] half_ticks(input logic first_half);
      return (code_sr[0] == first_half) ? cfg.long_phase_ticks : cfg.short_phase_ticks;
   endfunction

   function automatic result_type line_levels_after(input logic kind, input logic [7:0] code,
                                                    input logic busy);
      result_type r;
      r = '0;
      if (kind == REQ_SEND) begin
         if (ph != PH_IDLE) begin
            r.send_rejected = 1'b1;
         end else begin
            ph        = PH_RESET_LOW;
            ph_timer  = cfg.reset_low_ticks;
            bits_sent = '0;
            code_sr   = code;
            high_half = 1'b0;
         end
      end else if (ph != PH_IDLE) begin
         if (ph_timer > 1) begin
            ph_timer = ph_timer - 1'b1;
         end else begin
            case (ph)
               PH_RESET_LOW: begin
                  ph       = PH_RESET_HIGH;
                  ph_timer = cfg.reset_high_ticks;
               end
               PH_RESET_HIGH: begin
                  ph       = PH_START_LOW;
                  ph_timer = cfg.start_low_ticks;
               end
               PH_START_LOW: begin
                  ph        = PH_BITS;
                  bits_sent = '0;
                  high_half = 1'b1;
                  ph_timer  = half_ticks(1'b1);
               end
               PH_BITS: begin
                  if (high_half) begin
                     high_half = 1'b0;
                     ph_timer  = half_ticks(1'b0);
                  end else begin
                     code_sr   = code_sr >> 1;
                     bits_sent = bits_sent + 1'b1;
                     if (bits_sent >= CODE_BITS) begin
                        ph       = PH_GUARD;
                        ph_timer = cfg.guard_ticks;
                     end else begin
                        high_half = 1'b1;
                        ph_timer  = half_ticks(1'b1);
                     end
                  end
               end
               default: begin
                  ph           = PH_IDLE;
                  ph_timer     = '0;
                  bits_sent    = '0;
                  code_sr      = '0;
                  high_half    = 1'b0;
                  r.frame_done = 1'b1;
               end
            endcase
         end
      end
      r.data_level   = (ph == PH_START_LOW) ? 1'b0 : (ph == PH_BITS) ? high_half : 1'b1;
      r.reset_level  = (ph != PH_RESET_LOW);
      r.sending      = (ph != PH_IDLE);
      r.chip_playing = (busy == cfg.busy_active_level);
      return r;
   endfunction

   function automatic logic [CFG_TIME_WIDTH-1:0] pick_ticks(input int pass);
      if (pass == 0) return 16'd1;
      if (pass == 1) return 16'd0;
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'($urandom_range(7, 40));
         default: return 16'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic push_item(input logic kind, input logic [7:0] code, input logic busy,
                            input logic typed, input result_type want);
      int         gap;
      result_type due;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_code          <= code;
      req_chip_busy_pin <= busy;
      do @(posedge clock); while (req_stall);
      due = line_levels_after(kind, code, busy);
      levels_due.push_back(typed ? want : due);
      burst_left--;
   endtask

   task automatic random_item();
      logic kind;
      if (ph == PH_IDLE) begin
         kind = ($urandom_range(0, 9) < 6) ? REQ_SEND : REQ_TICK;
      end else begin
         kind = ($urandom_range(0, 19) == 0) ? REQ_SEND : REQ_TICK;
      end
      push_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (levels_due.size() != 0);
   endtask

   // run the current frame out, then wait for every result
   task automatic settle();
      while (ph != PH_IDLE) begin
         push_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      drain();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_TIME_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RESET_LOW:   cfg.reset_low_ticks   = data;
         CSR_RESET_HIGH:  cfg.reset_high_ticks  = data;
         CSR_START_LOW:   cfg.start_low_ticks   = data;
         CSR_SHORT_PHASE: cfg.short_phase_ticks = data;
         CSR_LONG_PHASE:  cfg.long_phase_ticks  = data;
         CSR_GUARD:       cfg.guard_ticks       = data;
         CSR_BUSY_LEVEL:  cfg.busy_active_level = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : receiver_pace
      if (stall_left == 0) begin
         stall_mode = stall_pattern_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      beat = beat + 1'b1;
      case (stall_mode)
         STALL_OFF:   rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= beat[2];
      endcase
   end

   always @(posedge clock) begin : check_results
      result_type got;
      result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_data_level, rsp_reset_level, rsp_sending, rsp_frame_done,
                rsp_send_rejected, rsp_chip_playing};
         if (levels_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %b", $time, got);
            mismatch_count++;
         end else begin
            due = levels_due.pop_front();
            for (int f = 5; f >= 0; f--) begin
               if (due[f] !== got[f]) begin
                  $display("%0t: %s expected %b actual %b", $time, field_name[f], due[f], got[f]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [CSR_INDEX_WIDTH-1:0] r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            settle();
            write_reg(plan[i].reg_sel, plan[i].value);
         end else begin
            push_item((plan[i].kind == ROW_SEND) ? REQ_SEND : REQ_TICK, plan[i].value[7:0],
                      plan[i].busy, plan[i].typed, plan[i].want);
         end
      end

      for (int pass = 0; pass < 8; pass++) begin
         settle();
         for (r = CSR_RESET_LOW; r <= CSR_GUARD; r++) write_reg(r, pick_ticks(pass));
         write_reg(CSR_BUSY_LEVEL, 16'($urandom_range(0, 1)));
         repeat (250) random_item();
      end

      // longest timings everywhere; the frame is left running at the end
      settle();
      for (r = CSR_RESET_LOW; r <= CSR_GUARD; r++) write_reg(r, 16'hFFFF);
      write_reg(CSR_BUSY_LEVEL, 16'($urandom_range(0, 1)));
      push_item(REQ_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      repeat (300) random_item();

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && levels_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
